>>> rtl/sbcu_pkg.sv
// Shared constants for the spanning-tree configuration message processor.
// No dependencies; used by the top level and by the port checker.
package sbcu_pkg;

    // Default number of attached ports (legal range 2 to 32).
    localparam int NUM_PORTS_DEF = 32;

    // Field widths fixed by the message and result formats.
    localparam int ID_W    = 8;
    localparam int DIST_W  = 8;
    localparam int PORT_W  = 5;
    localparam int RPORT_W = 6;
    localparam int MASK_W  = 32;
    localparam int CFG_W   = 32;
    localparam int CIDX_W  = 2;

    // Root port code meaning that there is no root port.
    localparam logic [RPORT_W-1:0] NO_PORT = 6'd32;

    // Saturation point of the hop distance.
    localparam logic [DIST_W-1:0] DIST_MAX = 8'hFF;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] REG_BRIDGE_ID   = 2'd0;
    localparam logic [CIDX_W-1:0] REG_PORT_ENABLE = 2'd1;

endpackage

>>> rtl/stp_bridge_config_update.sv
// Top level of the spanning-tree configuration message processor.
// Depends on sbcu_pkg for widths, register indexes and the no-port code.
// Holds the bridge's root view and port roles and updates them per message.
//
// Channel    | Direction | Handshake          | Payload
// -----------+-----------+--------------------+----------------------------------------
// message    | in        | i_valid / o_ready  | claimed_root, sender_distance,
//            |           |                    | sender_id, port_index
// result     | out       | o_valid / i_ready  | changed, root view, port role masks
// config     | in        | i_cfg_we           | i_cfg_index, i_cfg_wdata (no wait)
//
// Every message yields exactly one result item. A message goes through two
// registers: the input register and the result register. The root view and the
// port roles are read and rewritten in the single cycle in which a message
// moves from the input register to the result register, so one message per
// cycle is sustained while the result side does not stall.
// The ready on the input side follows the output: when a result waits, the
// input register can still take one more message, after which o_ready drops.
// Reset (synchronous, active low) clears the configuration, view and valid
// registers, so the bridge starts as its own root with id 0 and no port enabled.
// A configuration write takes effect at the edge at which i_cfg_we is high; the
// user must issue it only while no message is in flight (not enforced here).
module stp_bridge_config_update #(
    parameter int NUM_PORTS = sbcu_pkg::NUM_PORTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    // Configuration write port.
    input  logic                          i_cfg_we,
    input  logic [sbcu_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [sbcu_pkg::CFG_W-1:0]    i_cfg_wdata,

    // Message channel.
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [sbcu_pkg::ID_W-1:0]     i_claimed_root,
    input  logic [sbcu_pkg::DIST_W-1:0]   i_sender_distance,
    input  logic [sbcu_pkg::ID_W-1:0]     i_sender_id,
    input  logic [sbcu_pkg::PORT_W-1:0]   i_port_index,

    // Result channel.
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_changed,
    output logic [sbcu_pkg::ID_W-1:0]     o_root_id,
    output logic [sbcu_pkg::DIST_W-1:0]   o_root_distance,
    output logic [sbcu_pkg::ID_W-1:0]     o_next_hop_id,
    output logic [sbcu_pkg::RPORT_W-1:0]  o_root_port_index,
    output logic [sbcu_pkg::MASK_W-1:0]   o_designated_mask,
    output logic [sbcu_pkg::MASK_W-1:0]   o_blocked_mask
);

    // Configuration registers. Only the enable bits of existing ports are kept,
    // which also drops messages on ports at or above NUM_PORTS.
    logic [sbcu_pkg::ID_W-1:0]     r_bridge_id;
    logic [NUM_PORTS-1:0]          r_port_enable;

    // Root view and port roles.
    logic [sbcu_pkg::ID_W-1:0]     r_best_root,  n_best_root;
    logic [sbcu_pkg::DIST_W-1:0]   r_best_dist,  n_best_dist;
    logic [sbcu_pkg::ID_W-1:0]     r_next_hop,   n_next_hop;
    logic [sbcu_pkg::RPORT_W-1:0]  r_root_port,  n_root_port;
    logic [NUM_PORTS-1:0]          r_desig,      n_desig;
    logic [NUM_PORTS-1:0]          r_blocked,    n_blocked;

    // Input register.
    logic                          r_in_valid;
    logic [sbcu_pkg::ID_W-1:0]     r_in_root;
    logic [sbcu_pkg::DIST_W-1:0]   r_in_dist;
    logic [sbcu_pkg::ID_W-1:0]     r_in_from;
    logic [sbcu_pkg::PORT_W-1:0]   r_in_port;

    // Result register.
    logic                          r_out_valid;
    logic                          r_out_changed;
    logic [sbcu_pkg::ID_W-1:0]     r_out_root;
    logic [sbcu_pkg::DIST_W-1:0]   r_out_dist;
    logic [sbcu_pkg::ID_W-1:0]     r_out_hop;
    logic [sbcu_pkg::RPORT_W-1:0]  r_out_rport;
    logic [sbcu_pkg::MASK_W-1:0]   r_out_desig;
    logic [sbcu_pkg::MASK_W-1:0]   r_out_blocked;

    // Result of processing the message that sits in the input register.
    logic                          s_changed;
    logic [sbcu_pkg::ID_W-1:0]     s_best_root;
    logic [sbcu_pkg::DIST_W-1:0]   s_best_dist;
    logic [sbcu_pkg::ID_W-1:0]     s_next_hop;
    logic [sbcu_pkg::RPORT_W-1:0]  s_root_port;
    logic [NUM_PORTS-1:0]          s_desig;
    logic [NUM_PORTS-1:0]          s_blocked;

    logic                          w_adv;
    logic                          w_accept;
    logic [NUM_PORTS-1:0]          w_port_oh;
    logic [NUM_PORTS-1:0]          w_rport_oh;
    logic [NUM_PORTS-1:0]          w_new_en;
    logic [sbcu_pkg::DIST_W-1:0]   w_d1;
    logic                          w_live;
    logic                          w_same;
    logic                          w_better;
    logic                          w_block;
    logic [NUM_PORTS-1:0]          w_desig_rm;

    // The input register moves on when the result register is empty or its
    // item is being taken in this cycle.
    assign w_adv    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready  = !r_in_valid || w_adv;
    assign w_accept = i_valid && o_ready;

    // One-hot decodes of the arrival port and of the current root port. The
    // no-port code matches no bit.
    always_comb begin
        for (int p = 0; p < NUM_PORTS; p++) begin
            w_port_oh[p]  = (r_in_port == sbcu_pkg::PORT_W'(p));
            w_rport_oh[p] = (r_root_port == sbcu_pkg::RPORT_W'(p));
        end
    end

    // The offered distance is the sender's plus one hop, saturating.
    assign w_d1 = (r_in_dist == sbcu_pkg::DIST_MAX) ? sbcu_pkg::DIST_MAX
                                                    : r_in_dist + 8'd1;

    assign w_live = |(w_port_oh & r_port_enable);
    assign w_same = (r_in_root == r_best_root);

    // Priority vector: root, distance, sender against the next hop, then port.
    assign w_better = (r_in_root < r_best_root)
        || (w_same && (w_d1 < r_best_dist))
        || (w_same && (w_d1 == r_best_dist) && (r_in_from < r_next_hop))
        || (w_same && (w_d1 == r_best_dist) && (r_in_from == r_next_hop)
            && ({1'b0, r_in_port} < r_root_port));

    // An offer for the same root that is better than this bridge's own (lower
    // distance, or equal distance and a lower sender id) blocks a designated port.
    assign w_block = w_same
        && ((r_in_dist < r_best_dist)
            || ((r_in_dist == r_best_dist) && (r_in_from < r_bridge_id)))
        && (|(r_desig & w_port_oh));

    assign w_desig_rm = r_desig & ~w_port_oh;

    always_comb begin
        s_changed   = 1'b0;
        s_best_root = r_best_root;
        s_best_dist = r_best_dist;
        s_next_hop  = r_next_hop;
        s_root_port = r_root_port;
        s_desig     = r_desig;
        s_blocked   = r_blocked;
        if (w_live && w_better) begin
            // Adopt the offer: the arrival port becomes the root port and every
            // other enabled port is designated. With no designated port left the
            // arrival port is also blocked while it stays the reported root port.
            s_changed   = 1'b1;
            s_best_root = r_in_root;
            s_best_dist = w_d1;
            s_next_hop  = r_in_from;
            s_root_port = {1'b0, r_in_port};
            s_desig     = r_port_enable & ~w_port_oh;
            s_blocked   = (|(r_port_enable & ~w_port_oh)) ? '0 : w_port_oh;
        end else if (w_live && w_block) begin
            s_changed = 1'b1;
            s_desig   = w_desig_rm;
            s_blocked = r_blocked | w_port_oh;
            // Losing the last designated port also blocks the root port.
            if (!(|w_desig_rm) && (r_root_port != sbcu_pkg::NO_PORT)) begin
                s_blocked   = r_blocked | w_port_oh | w_rport_oh;
                s_root_port = sbcu_pkg::NO_PORT;
            end
        end
    end

    // Ports that a port enable write turns on.
    assign w_new_en = i_cfg_wdata[NUM_PORTS-1:0] & ~r_port_enable;

    always_comb begin
        n_best_root = w_adv ? s_best_root : r_best_root;
        n_best_dist = w_adv ? s_best_dist : r_best_dist;
        n_next_hop  = w_adv ? s_next_hop  : r_next_hop;
        n_root_port = w_adv ? s_root_port : r_root_port;
        n_desig     = w_adv ? s_desig     : r_desig;
        n_blocked   = w_adv ? s_blocked   : r_blocked;
        if (i_cfg_we) begin
            case (i_cfg_index)
                sbcu_pkg::REG_BRIDGE_ID: begin
                    // A new bridge id restarts the view with this bridge as root.
                    n_best_root = i_cfg_wdata[sbcu_pkg::ID_W-1:0];
                    n_best_dist = '0;
                    n_next_hop  = i_cfg_wdata[sbcu_pkg::ID_W-1:0];
                    n_root_port = sbcu_pkg::NO_PORT;
                    n_desig     = r_port_enable;
                    n_blocked   = '0;
                end
                sbcu_pkg::REG_PORT_ENABLE: begin
                    // Newly enabled ports become designated; disabled ports lose
                    // every role, the root port included.
                    n_desig   = (r_desig | w_new_en) & i_cfg_wdata[NUM_PORTS-1:0];
                    n_blocked = r_blocked & i_cfg_wdata[NUM_PORTS-1:0];
                    if (|(w_rport_oh & ~i_cfg_wdata[NUM_PORTS-1:0])) begin
                        n_root_port = sbcu_pkg::NO_PORT;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bridge_id   <= '0;
            r_port_enable <= '0;
            r_best_root   <= '0;
            r_best_dist   <= '0;
            r_next_hop    <= '0;
            r_root_port   <= sbcu_pkg::NO_PORT;
            r_desig       <= '0;
            r_blocked     <= '0;
        end else begin
            r_best_root <= n_best_root;
            r_best_dist <= n_best_dist;
            r_next_hop  <= n_next_hop;
            r_root_port <= n_root_port;
            r_desig     <= n_desig;
            r_blocked   <= n_blocked;
            if (i_cfg_we && (i_cfg_index == sbcu_pkg::REG_BRIDGE_ID)) begin
                r_bridge_id <= i_cfg_wdata[sbcu_pkg::ID_W-1:0];
            end
            if (i_cfg_we && (i_cfg_index == sbcu_pkg::REG_PORT_ENABLE)) begin
                r_port_enable <= i_cfg_wdata[NUM_PORTS-1:0];
            end
        end
    end

    // Valid bits of the input and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_root <= i_claimed_root;
            r_in_dist <= i_sender_distance;
            r_in_from <= i_sender_id;
            r_in_port <= i_port_index;
        end
        if (w_adv) begin
            r_out_changed <= s_changed;
            r_out_root    <= s_best_root;
            r_out_dist    <= s_best_dist;
            r_out_hop     <= s_next_hop;
            r_out_rport   <= s_root_port;
            r_out_desig   <= sbcu_pkg::MASK_W'(s_desig);
            r_out_blocked <= sbcu_pkg::MASK_W'(s_blocked);
        end
    end

    assign o_valid           = r_out_valid;
    assign o_changed         = r_out_changed;
    assign o_root_id         = r_out_root;
    assign o_root_distance   = r_out_dist;
    assign o_next_hop_id     = r_out_hop;
    assign o_root_port_index = r_out_rport;
    assign o_designated_mask = r_out_desig;
    assign o_blocked_mask    = r_out_blocked;

endmodule

>>> rtl/sbcu_checker.sv
// Port-level checks for the spanning-tree configuration message processor.
// Depends on sbcu_pkg; bound to stp_bridge_config_update at the end of the file.
module sbcu_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic                          o_changed,
    input logic [sbcu_pkg::ID_W-1:0]     o_root_id,
    input logic [sbcu_pkg::DIST_W-1:0]   o_root_distance,
    input logic [sbcu_pkg::ID_W-1:0]     o_next_hop_id,
    input logic [sbcu_pkg::RPORT_W-1:0]  o_root_port_index,
    input logic [sbcu_pkg::MASK_W-1:0]   o_designated_mask,
    input logic [sbcu_pkg::MASK_W-1:0]   o_blocked_mask
);

    // A stalled result item holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_changed) && $stable(o_root_id)
            && $stable(o_root_distance) && $stable(o_next_hop_id)
            && $stable(o_root_port_index) && $stable(o_designated_mask)
            && $stable(o_blocked_mask))
        else $error("result item changed while stalled");

    // No port is both designated and blocked.
    a_roles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_designated_mask & o_blocked_mask) == '0))
        else $error("port both designated and blocked");

    // The root port is never designated at the same time and is always below 32.
    a_rport: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_root_port_index != sbcu_pkg::NO_PORT)
            |-> !o_designated_mask[o_root_port_index[4:0]] && !o_root_port_index[5])
        else $error("root port also designated or out of range");

    // Being at distance zero means being the root, which has no root port.
    a_self: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_root_distance == '0) |-> (o_root_port_index == sbcu_pkg::NO_PORT))
        else $error("root port present at distance zero");

endmodule

bind stp_bridge_config_update sbcu_checker u_sbcu_checker (.*);
